FILE: design/ffa_pkg.sv
// Shared types and constants for the first-fit free-list allocator.
package ffa_pkg;

  localparam int unsigned TableEntries = 4096;
  localparam int unsigned IdxW         = $clog2(TableEntries);
  localparam int unsigned CntW         = $clog2(TableEntries + 1);

  localparam logic [31:0] PageAdd  = 32'h0000_0fff;
  localparam logic [31:0] PageMask = 32'hffff_f000;

  localparam logic       ActAlloc = 1'b0;
  localparam logic       ActFree  = 1'b1;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StNoFit   = 2'd1;
  localparam logic [1:0] StLost    = 2'd2;

  typedef struct packed {
    logic        action;
    logic [31:0] region_start;
    logic [31:0] region_bytes;
    logic        round_to_page;
  } req_t;

  typedef struct packed {
    logic [31:0]     granted_start;
    logic [1:0]      status;
    logic [31:0]     free_total;
    logic [CntW-1:0] entries_used;
    logic [CntW-1:0] peak_entries;
    logic [31:0]     lost_count;
    logic [31:0]     lost_bytes;
  } rsp_t;

  // One table entry: start and size held side by side in one word.
  typedef struct packed {
    logic [31:0] start;
    logic [31:0] size;
  } ent_t;

endpackage

FILE: design/ffa_if.sv
// Valid/ready channel interfaces for requests and results.
interface ffa_req_if (input logic clk);
  logic           valid;
  logic           ready;
  ffa_pkg::req_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ffa_rsp_if (input logic clk);
  logic           valid;
  logic           ready;
  ffa_pkg::rsp_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: design/first_fit_free_list_allocator.sv
// Top level: first-fit free-list allocator with coalescing over a table RAM.
//
//   channel | dir | words         | handshake
//   in_     | in  | req_t         | valid/ready
//   out_    | out | rsp_t         | valid/ready
//
// One request at a time. An allocate scans the table from entry 0 (the RAM read is
// registered), one entry per pass through S_SCANW and S_SCAN, and, when an entry
// empties, shifts the tail down one entry per pass through S_DOWN and S_NEXT. A free
// scans to its slot and may shift the tail up or down. Reset clears the state, the
// counters and the output valid only; the table needs no clearing. The result is held
// in an output register; a stalled output holds the next request off.
module first_fit_free_list_allocator (
  input  logic       clk,
  input  logic       rst_n,
  ffa_req_if.sink    in_ch,
  ffa_rsp_if.source  out_ch
);
  localparam int unsigned IW = ffa_pkg::IdxW;
  localparam int unsigned CW = ffa_pkg::CntW;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SCAN  = 9'b000000010,
    S_SCANW = 9'b000000100,
    S_DOWN  = 9'b000001000,
    S_DOWNW = 9'b000010000,
    S_UP    = 9'b000100000,
    S_UPW   = 9'b001000000,
    S_NEXT  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t            state_r, state_nxt;
  logic              act_r;
  logic [31:0]       at_r, sz_r;
  logic [CW-1:0]     k_r, k_nxt;       // scan / shift index
  logic [CW-1:0]     cnt_r, peak_r;
  logic [31:0]       total_r, lcnt_r, lbytes_r;
  ffa_pkg::ent_t     prev_r;           // entry pos-1 for a free
  logic              have_prev_r;
  logic [31:0]       grant_r;
  logic [1:0]        st_r;
  logic              ov_r;
  ffa_pkg::rsp_t     od_r;

  logic              we;
  logic [IW-1:0]     waddr, raddr;
  ffa_pkg::ent_t     wdata, rdata;

  ffa_ram u_ram (.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
                 .raddr(raddr), .rdata(rdata));

  logic [31:0] sz_in;
  assign sz_in = in_ch.data.round_to_page ?
                 ((in_ch.data.region_bytes + ffa_pkg::PageAdd) & ffa_pkg::PageMask) :
                 in_ch.data.region_bytes;

  assign in_ch.ready  = (state_r == S_IDLE) && !ov_r;
  assign out_ch.valid = ov_r;
  assign out_ch.data  = od_r;

  // Registered-read address: the entry at k_r, or k_r+1 during a down-shift.
  always_comb begin
    raddr = k_r[IW-1:0];
    if (state_r == S_DOWN) raddr = IW'(k_r + 1'b1);
  end

  // Scratch values for the free-side decisions.
  logic [31:0] prev_end, new_end;
  logic        at_end;
  assign prev_end = prev_r.start + prev_r.size;
  assign new_end  = at_r + sz_r;
  assign at_end   = (k_r == cnt_r);

  logic [CW-1:0] cnt_nxt, peak_nxt;
  logic [31:0]   total_nxt, lcnt_nxt, lbytes_nxt, grant_nxt;
  logic [1:0]    st_nxt;
  ffa_pkg::ent_t prev_nxt;
  logic          have_prev_nxt;

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    cnt_nxt       = cnt_r;
    peak_nxt      = peak_r;
    total_nxt     = total_r;
    lcnt_nxt      = lcnt_r;
    lbytes_nxt    = lbytes_r;
    grant_nxt     = grant_r;
    st_nxt        = st_r;
    prev_nxt      = prev_r;
    have_prev_nxt = have_prev_r;
    we            = 1'b0;
    waddr         = k_r[IW-1:0];
    wdata         = rdata;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          k_nxt         = '0;
          have_prev_nxt = 1'b0;
          grant_nxt     = '0;
          st_nxt        = ffa_pkg::StOk;
          state_nxt     = S_SCANW;
        end
      end
      S_SCANW: state_nxt = S_SCAN;   // wait for read data at k_r
      S_SCAN: begin
        if (act_r == ffa_pkg::ActAlloc) begin
          if (at_end) begin
            st_nxt    = ffa_pkg::StNoFit;
            state_nxt = S_DONE;
          end else if (rdata.size >= sz_r) begin
            grant_nxt = rdata.start;
            total_nxt = total_r - sz_r;
            if (rdata.size == sz_r) begin
              cnt_nxt   = cnt_r - 1'b1;
              state_nxt = S_DOWN;
            end else begin
              we          = 1'b1;
              wdata.start = rdata.start + sz_r;
              wdata.size  = rdata.size - sz_r;
              state_nxt   = S_DONE;
            end
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = S_SCANW;
          end
        end else begin
          if (!at_end && !(rdata.start > at_r)) begin
            prev_nxt      = rdata;
            have_prev_nxt = 1'b1;
            k_nxt         = k_r + 1'b1;
            state_nxt     = S_SCANW;
          end else if (have_prev_r && prev_end == at_r) begin
            total_nxt = total_r + sz_r;
            we        = 1'b1;
            waddr     = IW'(k_r - 1'b1);
            wdata.start = prev_r.start;
            if (!at_end && new_end == rdata.start) begin
              wdata.size = prev_r.size + sz_r + rdata.size;
              cnt_nxt    = cnt_r - 1'b1;
              state_nxt  = S_DOWNW;
            end else begin
              wdata.size = prev_r.size + sz_r;
              state_nxt  = S_DONE;
            end
          end else if (!at_end && new_end == rdata.start) begin
            total_nxt   = total_r + sz_r;
            we          = 1'b1;
            wdata.start = at_r;
            wdata.size  = rdata.size + sz_r;
            state_nxt   = S_DONE;
          end else if (cnt_r < CW'(ffa_pkg::TableEntries)) begin
            total_nxt = total_r + sz_r;
            cnt_nxt   = cnt_r + 1'b1;
            if (peak_r < cnt_r + 1'b1) peak_nxt = cnt_r + 1'b1;
            prev_nxt.start = at_r;     // entry to drop into slot pos
            prev_nxt.size  = sz_r;
            if (at_end) begin
              we          = 1'b1;
              wdata.start = at_r;
              wdata.size  = sz_r;
              state_nxt   = S_DONE;
            end else begin
              // carry the displaced entry upward, one slot per pass through S_UPW and S_UP
              we          = 1'b1;
              wdata.start = at_r;
              wdata.size  = sz_r;
              prev_nxt    = rdata;
              k_nxt       = k_r + 1'b1;
              state_nxt   = S_UPW;
            end
          end else begin
            st_nxt     = ffa_pkg::StLost;
            lcnt_nxt   = lcnt_r + 1'b1;
            lbytes_nxt = lbytes_r + sz_r;
            state_nxt  = S_DONE;
          end
        end
      end
      // Up-shift: write carried entry at k, read old entry at k first.
      S_UPW: begin
        if (k_r == cnt_r - 1'b1) begin
          we        = 1'b1;
          wdata     = prev_r;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_UP;
        end
      end
      S_UP: begin
        we        = 1'b1;
        wdata     = prev_r;
        prev_nxt  = rdata;
        k_nxt     = k_r + 1'b1;
        state_nxt = S_UPW;
      end
      // Down-shift: entry k+1 moves to k, for k from k_r up to cnt_r-1.
      S_DOWNW: begin
        // entry at k_r was merged away; shift from there
        state_nxt = (k_r >= cnt_r) ? S_DONE : S_DOWN;
      end
      S_DOWN: begin
        if (k_r >= cnt_r) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        we        = 1'b1;
        wdata     = rdata;
        k_nxt     = k_r + 1'b1;
        state_nxt = S_DOWN;
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      peak_r   <= '0;
      total_r  <= '0;
      lcnt_r   <= '0;
      lbytes_r <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      peak_r   <= peak_nxt;
      total_r  <= total_nxt;
      lcnt_r   <= lcnt_nxt;
      lbytes_r <= lbytes_nxt;
      if (out_ch.valid && out_ch.ready) ov_r <= 1'b0;
      if (state_r == S_DONE) ov_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    k_r         <= k_nxt;
    grant_r     <= grant_nxt;
    st_r        <= st_nxt;
    prev_r      <= prev_nxt;
    have_prev_r <= have_prev_nxt;
    if (in_ch.valid && in_ch.ready) begin
      act_r <= in_ch.data.action;
      at_r  <= in_ch.data.region_start;
      sz_r  <= sz_in;
    end
    if (state_r == S_DONE) begin
      od_r.granted_start <= grant_r;
      od_r.status        <= st_r;
      od_r.free_total    <= total_r;
      od_r.entries_used  <= cnt_r;
      od_r.peak_entries  <= peak_r;
      od_r.lost_count    <= lcnt_r;
      od_r.lost_bytes    <= lbytes_r;
    end
  end
endmodule

FILE: design/ffa_ram.sv
// Single-port-write, single-port-read table RAM with registered read data.
module ffa_ram (
  input  logic                    clk,
  input  logic                    we,
  input  logic [ffa_pkg::IdxW-1:0] waddr,
  input  ffa_pkg::ent_t           wdata,
  input  logic [ffa_pkg::IdxW-1:0] raddr,
  output ffa_pkg::ent_t           rdata
);
  ffa_pkg::ent_t mem [ffa_pkg::TableEntries];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the first-fit free-list allocator.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 20000;

  typedef struct {
    ffa_pkg::req_t req;
    ffa_pkg::rsp_t rsp;
    logic [31:0]   bytes;
  } alloc_exp_t;

  logic clk;
  logic rst_n;

  ffa_req_if req_ch (clk);
  ffa_rsp_if rsp_ch (clk);

  first_fit_free_list_allocator u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch.sink),
    .out_ch (rsp_ch.source)
  );

  // Shadow of the free-region table.
  logic [31:0] shadow_start [ffa_pkg::TableEntries];
  logic [31:0] shadow_size  [ffa_pkg::TableEntries];
  int          shadow_cnt;
  int          shadow_peak;
  logic [31:0] shadow_total;
  logic [31:0] shadow_lost_n;
  logic [31:0] shadow_lost_b;

  ffa_pkg::req_t pending_reqs[$];
  alloc_exp_t    expected_rsps[$];
  logic [31:0]   granted_at[$];
  logic [31:0]   granted_len[$];

  int  tx_idle_pct;
  int  rx_idle_pct;
  bit  rx_hold_go;
  int  rx_hold_left;
  bit  req_taken;
  int  fail_cnt;
  int  quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [31:0] page_round(ffa_pkg::req_t r);
    if (r.round_to_page) return (r.region_bytes + ffa_pkg::PageAdd) & ffa_pkg::PageMask;
    return r.region_bytes;
  endfunction

  function automatic void remove_region(int idx);
    shadow_cnt--;
    for (int k = idx; k < shadow_cnt; k++) begin
      shadow_start[k] = shadow_start[k+1];
      shadow_size[k]  = shadow_size[k+1];
    end
  endfunction

  function automatic ffa_pkg::rsp_t allocator_predict(ffa_pkg::req_t r);
    ffa_pkg::rsp_t o;
    logic [31:0]   sz;
    int            pos;
    bit            done;
    o = '0;
    o.status = ffa_pkg::StOk;
    sz = page_round(r);
    done = 1'b0;
    if (r.action == ffa_pkg::ActAlloc) begin
      o.status = ffa_pkg::StNoFit;
      for (int k = 0; k < shadow_cnt && !done; k++) begin
        if (shadow_size[k] >= sz) begin
          o.granted_start = shadow_start[k];
          o.status = ffa_pkg::StOk;
          shadow_start[k] += sz;
          shadow_size[k]  -= sz;
          shadow_total    -= sz;
          if (shadow_size[k] == 32'd0) remove_region(k);
          done = 1'b1;
        end
      end
    end else begin
      pos = 0;
      while (pos < shadow_cnt && shadow_start[pos] <= r.region_start) pos++;
      if (pos > 0 && shadow_start[pos-1] + shadow_size[pos-1] == r.region_start) begin
        shadow_size[pos-1] += sz;
        // the merged region may now touch its successor
        if (pos < shadow_cnt && r.region_start + sz == shadow_start[pos]) begin
          shadow_size[pos-1] += shadow_size[pos];
          remove_region(pos);
        end
        shadow_total += sz;
      end else if (pos < shadow_cnt && r.region_start + sz == shadow_start[pos]) begin
        shadow_start[pos] = r.region_start;
        shadow_size[pos] += sz;
        shadow_total     += sz;
      end else if (shadow_cnt < ffa_pkg::TableEntries) begin
        for (int k = shadow_cnt; k > pos; k--) begin
          shadow_start[k] = shadow_start[k-1];
          shadow_size[k]  = shadow_size[k-1];
        end
        shadow_cnt++;
        if (shadow_peak < shadow_cnt) shadow_peak = shadow_cnt;
        shadow_start[pos] = r.region_start;
        shadow_size[pos]  = sz;
        shadow_total     += sz;
      end else begin
        shadow_lost_n += 32'd1;
        shadow_lost_b += sz;
        o.status = ffa_pkg::StLost;
      end
    end
    o.free_total   = shadow_total;
    o.entries_used = shadow_cnt[ffa_pkg::CntW-1:0];
    o.peak_entries = shadow_peak[ffa_pkg::CntW-1:0];
    o.lost_count   = shadow_lost_n;
    o.lost_bytes   = shadow_lost_b;
    return o;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      fail_cnt++;
    end
  endfunction

  // Sender: present a word at the falling edge, hold it until taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
      req_ch.data  <= '0;
    end else if (!req_ch.valid || req_taken) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        req_ch.valid <= 1'b1;
        req_ch.data  <= pending_reqs.pop_front();
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure plus one long hold-off on request.
  always @(negedge clk) begin
    if (rx_hold_go) begin
      rx_hold_left = 300;
      rx_hold_go   = 1'b0;
    end
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left--;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Monitor: check results first, then predict for the word accepted now.
  always @(posedge clk) begin
    alloc_exp_t e;
    req_taken <= req_ch.valid && req_ch.ready;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_rsps.size() == 0) begin
        $error("result word with nothing expected");
        fail_cnt++;
      end else begin
        e = expected_rsps.pop_front();
        check_field("granted_start", e.rsp.granted_start, rsp_ch.data.granted_start);
        check_field("status", 32'(e.rsp.status), 32'(rsp_ch.data.status));
        check_field("free_total", e.rsp.free_total, rsp_ch.data.free_total);
        check_field("entries_used", 32'(e.rsp.entries_used),
                    32'(rsp_ch.data.entries_used));
        check_field("peak_entries", 32'(e.rsp.peak_entries),
                    32'(rsp_ch.data.peak_entries));
        check_field("lost_count", e.rsp.lost_count, rsp_ch.data.lost_count);
        check_field("lost_bytes", e.rsp.lost_bytes, rsp_ch.data.lost_bytes);
        if (e.req.action == ffa_pkg::ActAlloc && e.rsp.status == ffa_pkg::StOk &&
            e.bytes != 0) begin
          granted_at.push_back(e.rsp.granted_start);
          granted_len.push_back(e.bytes);
        end
      end
    end
    if (rst_n && req_ch.valid && req_ch.ready) begin
      e.req   = req_ch.data;
      e.bytes = page_round(req_ch.data);
      e.rsp   = allocator_predict(req_ch.data);
      expected_rsps.push_back(e);
    end
  end

  // Watchdog on cycles with no word moving on either side.
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic ffa_pkg::req_t make_req(logic act, logic [31:0] at, logic [31:0] len,
                                             logic rnd);
    ffa_pkg::req_t r;
    r.action        = act;
    r.region_start  = at;
    r.region_bytes  = len;
    r.round_to_page = rnd;
    return r;
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || req_ch.valid || expected_rsps.size() > 0)
      @(posedge clk);
  endtask

  task automatic random_phase(int n);
    ffa_pkg::req_t r;
    int            pick;
    int            dice;
    for (int i = 0; i < n; i++) begin
      while (pending_reqs.size() >= 2) @(posedge clk);
      dice = $urandom_range(99);
      if (shadow_total < 32'h0010_0000 && dice < 10) begin
        r = make_req(ffa_pkg::ActFree, 32'h4000_0000 + ($urandom_range(255) << 20),
                     32'h0010_0000, 1'b0);
      end else if (dice < 45) begin
        if ($urandom_range(1))
          r = make_req(ffa_pkg::ActAlloc, $urandom, $urandom_range(1, 8) << 12, 1'b0);
        else
          r = make_req(ffa_pkg::ActAlloc, $urandom, $urandom_range(1, 20000),
                       1'($urandom_range(1)));
      end else if (dice < 85 && granted_at.size() > 0) begin
        // return a granted block, so neighbours coalesce
        pick = $urandom_range(granted_at.size() - 1);
        r = make_req(ffa_pkg::ActFree, granted_at[pick], granted_len[pick], 1'b0);
        granted_at.delete(pick);
        granted_len.delete(pick);
      end else begin
        r = make_req(1'($urandom_range(1)), $urandom, $urandom, 1'($urandom_range(1)));
      end
      pending_reqs.push_back(r);
    end
  endtask

  initial begin
    fail_cnt     = 0;
    quiet_cycles = 0;
    rx_hold_go   = 1'b0;
    rx_hold_left = 0;
    req_taken    = 1'b0;
    shadow_cnt   = 0;
    shadow_peak  = 0;
    shadow_total = '0;
    shadow_lost_n = '0;
    shadow_lost_b = '0;
    tx_idle_pct  = 31;
    rx_idle_pct  = 59;
    rst_n        = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    rsp_ch.ready = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // empty table, page-round wrap to zero, then every merge shape
    pending_reqs.push_back(make_req(ffa_pkg::ActAlloc, 32'h0, 32'h0, 1'b0));
    pending_reqs.push_back(make_req(ffa_pkg::ActAlloc, 32'hffff_ffff, 32'hffff_ffff, 1'b1));
    pending_reqs.push_back(make_req(ffa_pkg::ActFree, 32'h2000, 32'h1000, 1'b0));
    pending_reqs.push_back(make_req(ffa_pkg::ActFree, 32'h3000, 32'h0fff, 1'b1));
    pending_reqs.push_back(make_req(ffa_pkg::ActFree, 32'h1000, 32'h1000, 1'b0));
    pending_reqs.push_back(make_req(ffa_pkg::ActFree, 32'h6000, 32'h1000, 1'b0));
    pending_reqs.push_back(make_req(ffa_pkg::ActFree, 32'h4000, 32'h2000, 1'b0));
    pending_reqs.push_back(make_req(ffa_pkg::ActAlloc, 32'h0, 32'h0, 1'b0));
    pending_reqs.push_back(make_req(ffa_pkg::ActAlloc, 32'h0, 32'h1001, 1'b1));
    pending_reqs.push_back(make_req(ffa_pkg::ActAlloc, 32'h0, 32'h0010_0000, 1'b0));
    pending_reqs.push_back(make_req(ffa_pkg::ActFree, 32'hffff_f000, 32'h1000, 1'b0));
    pending_reqs.push_back(make_req(ffa_pkg::ActFree, 32'h0, 32'h1000, 1'b0));
    pending_reqs.push_back(make_req(ffa_pkg::ActFree, 32'h9000, 32'h0, 1'b0));
    pending_reqs.push_back(make_req(ffa_pkg::ActAlloc, 32'h0, 32'hffff_f001, 1'b1));
    pending_reqs.push_back(make_req(ffa_pkg::ActAlloc, 32'h0, 32'h5000, 1'b0));
    pending_reqs.push_back(make_req(ffa_pkg::ActFree, 32'hffff_ffff, 32'hffff_ffff, 1'b0));
    pending_reqs.push_back(make_req(ffa_pkg::ActAlloc, 32'h0, 32'hffff_ffff, 1'b0));
    pending_reqs.push_back(make_req(ffa_pkg::ActFree, 32'h8000_0000, 32'h8000_0000, 1'b1));
    pending_reqs.push_back(make_req(ffa_pkg::ActAlloc, 32'h0, 32'h7fff_ffff, 1'b0));
    wait_drained();

    // long receiver hold-off while the sender keeps offering
    rx_hold_go = 1'b1;
    random_phase(34);
    wait_drained();

    tx_idle_pct = 59;
    rx_idle_pct = 31;
    random_phase(33);
    wait_drained();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_phase(33);
    wait_drained();

    repeat (50) @(posedge clk);
    if (fail_cnt == 0 && expected_rsps.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
